### sv/ptc_pkg.sv
// shared types and constants of the pressure temperature compensation block
package ptc_pkg;

  // field widths
  localparam int RawW    = 24;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 8;
  localparam int OutW    = 32;

  // pipeline depth, the last stage is the output register
  localparam int NStages = 11;

  // internal value widths
  localparam int DtW   = 25;
  localparam int ProdW = 42;
  localparam int DevW  = 18;
  localparam int OffW  = 36;
  localparam int SensW = 35;
  localparam int SqW   = 35;
  localparam int Corr2W = 38;
  localparam int CorrW = 40;

  // compensation constants
  localparam int TempRef      = 2000;
  localparam int TempCold     = 1500;
  localparam int TempShift    = 23;
  localparam int OffShift     = 7;
  localparam int SensShift    = 8;
  localparam int OffBaseSh    = 16;
  localparam int SensBaseSh   = 15;
  localparam int SensDivShift = 21;
  localparam int PDivShift    = 15;
  localparam int RefTempSh    = 8;

  // deviation bound of the very cold band and offset to its upper edge
  localparam int ColdBound = TempRef + TempCold;
  localparam logic signed [DevW-1:0] DevVcold = DevW'(-ColdBound);
  localparam logic signed [DevW:0]   ColdOfs  = (DevW + 1)'(ColdBound);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSensBase   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegOffBase    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegSensTempco = 8'd2;
  localparam logic [CfgIdxW-1:0] RegOffTempco  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegRefTemp    = 8'd4;
  localparam logic [CfgIdxW-1:0] RegTempSlope  = 8'd5;

  typedef struct packed {
    logic [CfgW-1:0] sens_base;
    logic [CfgW-1:0] offset_base;
    logic [CfgW-1:0] sens_tempco;
    logic [CfgW-1:0] offset_tempco;
    logic [CfgW-1:0] ref_temperature;
    logic [CfgW-1:0] temp_slope;
  } cfg_t;

  // first-order terms leaving the front stages
  typedef struct packed {
    logic [RawW-1:0]        d1;
    logic signed [DevW-1:0] dev;
    logic signed [DevW:0]   cold_dev;
    logic                   cold;
    logic                   vcold;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
  } front_t;

  // corrected offset and sensitivity
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [CorrW-1:0] offc;
    logic signed [CorrW-1:0] sensc;
  } corr_t;

  // pipeline control
  typedef struct packed {
    logic [NStages-1:0] en;
    logic               out_valid;
  } pipe_ctl_t;

endpackage

### sv/ptc_if.sv
// channel interfaces: conversion input, pressure output, register writes
interface ptc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ptc_pkg::RawW-1:0]   raw_pressure;
  logic [ptc_pkg::RawW-1:0]   raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface ptc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ptc_pkg::OutW-1:0] pressure_out;
  modport source (output valid, pressure_out, input ready);
  modport sink (input valid, pressure_out, output ready);
endinterface

interface ptc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ptc_pkg::CfgIdxW-1:0] index;
  logic [ptc_pkg::CfgW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/pressure_temperature_compensation.sv
// top level: calibration registers and the eleven-stage compensation pipeline
//
//   channel  dir  payload                              beat when
//   in_i     in   raw_pressure, raw_temperature (24)   valid && ready
//   out_o    out  pressure_out (32, signed)            valid && ready
//   cfg_i    in   index (8), data (16)                 valid && ready
//
// one beat per cycle in and out while out_o.ready is high; the stage chain is
// subtract, multiply, shift-add, square, band add, subtract, split multiply,
// recombine, divide, offset subtract and the final divide into the output
// register
// empty stages fill while the output stalls, so ready drops only when all
// eleven stages hold a beat; ready depends combinationally on out_o.ready
// reset clears the calibration words and the valid bits; cfg_i is always ready
module pressure_temperature_compensation (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptc_in_if.sink     in_i,
  ptc_out_if.source  out_o,
  ptc_cfg_if.sink    cfg_i
);

  ptc_pkg::cfg_t      cfg_q;
  ptc_pkg::pipe_ctl_t ctl;
  ptc_pkg::front_t    front;
  ptc_pkg::corr_t     corr;
  logic               in_ready;

  // calibration registers, out-of-range indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ptc_pkg::RegSensBase:   cfg_q.sens_base       <= cfg_i.data;
        ptc_pkg::RegOffBase:    cfg_q.offset_base     <= cfg_i.data;
        ptc_pkg::RegSensTempco: cfg_q.sens_tempco     <= cfg_i.data;
        ptc_pkg::RegOffTempco:  cfg_q.offset_tempco   <= cfg_i.data;
        ptc_pkg::RegRefTemp:    cfg_q.ref_temperature <= cfg_i.data;
        ptc_pkg::RegTempSlope:  cfg_q.temp_slope      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  ptc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .ctl_o       (ctl)
  );

  assign in_i.ready = in_ready;

  // datapath
  ptc_front u_front (
    .clk_i             (clk_i),
    .en_i              (ctl.en[2:0]),
    .raw_pressure_i    (in_i.raw_pressure),
    .raw_temperature_i (in_i.raw_temperature),
    .cfg_i             (cfg_q),
    .front_o           (front)
  );

  ptc_corr u_corr (
    .clk_i   (clk_i),
    .en_i    (ctl.en[5:3]),
    .front_i (front),
    .corr_o  (corr)
  );

  ptc_scale u_scale (
    .clk_i          (clk_i),
    .en_i           (ctl.en[10:6]),
    .corr_i         (corr),
    .pressure_out_o (out_o.pressure_out)
  );

  assign out_o.valid = ctl.out_valid;

endmodule

### sv/ptc_pipe_ctrl.sv
// stage valid bits and per-stage enables with bubble squeezing
module ptc_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output ptc_pkg::pipe_ctl_t ctl_o
);

  logic [ptc_pkg::NStages-1:0] v_q, v_d, en;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[ptc_pkg::NStages-1] = !v_q[ptc_pkg::NStages-1] || out_ready_i;
    for (int k = ptc_pkg::NStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // valid bits follow their data
  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < ptc_pkg::NStages; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o      = en[0];
  assign ctl_o.en        = en;
  assign ctl_o.out_valid = v_q[ptc_pkg::NStages-1];

endmodule

### sv/ptc_front.sv
// stages 1 to 3: temperature difference, coefficient products, first-order terms
module ptc_front (
  input  logic                     clk_i,
  input  logic [2:0]               en_i,
  input  logic [ptc_pkg::RawW-1:0] raw_pressure_i,
  input  logic [ptc_pkg::RawW-1:0] raw_temperature_i,
  input  ptc_pkg::cfg_t            cfg_i,
  output ptc_pkg::front_t          front_o
);

  logic signed [ptc_pkg::DtW-1:0]   dt_d, dt_q;
  logic [ptc_pkg::RawW-1:0]         d1_s1_q, d1_s2_q;
  logic signed [ptc_pkg::ProdW-1:0] tp_d, tp_q, op_d, op_q, sp_d, sp_q;
  ptc_pkg::front_t                  f_d, f_q;

  // stage 1: dT = D2 - C5 * 256
  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cfg_i.ref_temperature, 8'b0});

  // stage 2: the three coefficient products
  assign tp_d = dt_q * $signed({1'b0, cfg_i.temp_slope});
  assign op_d = dt_q * $signed({1'b0, cfg_i.offset_tempco});
  assign sp_d = dt_q * $signed({1'b0, cfg_i.sens_tempco});

  // stage 3: floor shifts, base terms and band flags
  always_comb begin
    f_d.d1       = d1_s2_q;
    f_d.dev      = tp_q[ptc_pkg::TempShift + ptc_pkg::DevW - 1:ptc_pkg::TempShift];
    f_d.cold     = f_d.dev[ptc_pkg::DevW-1];
    f_d.vcold    = f_d.dev < ptc_pkg::DevVcold;
    f_d.cold_dev = $signed({f_d.dev[ptc_pkg::DevW-1], f_d.dev}) + ptc_pkg::ColdOfs;
    f_d.off      = $signed({4'b0, cfg_i.offset_base, 16'b0})
                 + $signed({op_q[ptc_pkg::ProdW-1], op_q[ptc_pkg::ProdW-1:ptc_pkg::OffShift]});
    f_d.sens     = $signed({4'b0, cfg_i.sens_base, 15'b0})
                 + $signed({sp_q[ptc_pkg::ProdW-1], sp_q[ptc_pkg::ProdW-1:ptc_pkg::SensShift]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_pressure_i;
    end
    if (en_i[1]) begin
      tp_q    <= tp_d;
      op_q    <= op_d;
      sp_q    <= sp_d;
      d1_s2_q <= d1_s1_q;
    end
    if (en_i[2]) begin
      f_q <= f_d;
    end
  end

  assign front_o = f_q;

endmodule

### sv/ptc_corr.sv
// stages 4 to 6: squares, second-order band corrections, corrected terms
module ptc_corr (
  input  logic            clk_i,
  input  logic [2:0]      en_i,
  input  ptc_pkg::front_t front_i,
  output ptc_pkg::corr_t  corr_o
);

  logic signed [2*ptc_pkg::DevW-1:0] dev_sq;
  logic signed [2*ptc_pkg::DevW+1:0] cold_sq;
  logic [ptc_pkg::SqW-1:0]           sq_d, sq_q, cc_d, cc_q;
  logic [ptc_pkg::Corr2W-1:0]        sq_e, cc_e;
  logic [ptc_pkg::Corr2W-1:0]        off2_d, off2_q, sens2_d, sens2_q;
  logic                              cold_s4_q, vcold_s4_q;
  logic signed [ptc_pkg::OffW-1:0]   off_s4_q, off_s5_q;
  logic signed [ptc_pkg::SensW-1:0]  sens_s4_q, sens_s5_q;
  logic [ptc_pkg::RawW-1:0]          d1_s4_q, d1_s5_q;
  ptc_pkg::corr_t                    c_d, c_q;

  // stage 4: squares of the deviations
  assign dev_sq  = front_i.dev * front_i.dev;
  assign cold_sq = front_i.cold_dev * front_i.cold_dev;
  assign sq_d    = dev_sq[ptc_pkg::SqW-1:0];
  assign cc_d    = cold_sq[ptc_pkg::SqW-1:0];

  // stage 5: OFF2 and SENS2 per band
  assign sq_e = {3'b0, sq_q};
  assign cc_e = {3'b0, cc_q};

  always_comb begin
    if (!cold_s4_q) begin
      off2_d  = sq_e >> 4;
      sens2_d = '0;
    end else if (!vcold_s4_q) begin
      off2_d  = ((sq_e << 1) + sq_e) >> 1;
      sens2_d = ((sq_e << 2) + sq_e) >> 3;
    end else begin
      off2_d  = (((sq_e << 1) + sq_e) >> 1) + (cc_e << 3) - cc_e;
      sens2_d = (((sq_e << 2) + sq_e) >> 3) + (cc_e << 2);
    end
  end

  // stage 6: subtract the corrections
  always_comb begin
    c_d.d1    = d1_s5_q;
    c_d.offc  = $signed({{4{off_s5_q[ptc_pkg::OffW-1]}}, off_s5_q})
              - $signed({2'b0, off2_q});
    c_d.sensc = $signed({{5{sens_s5_q[ptc_pkg::SensW-1]}}, sens_s5_q})
              - $signed({2'b0, sens2_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q       <= sq_d;
      cc_q       <= cc_d;
      cold_s4_q  <= front_i.cold;
      vcold_s4_q <= front_i.vcold;
      off_s4_q   <= front_i.off;
      sens_s4_q  <= front_i.sens;
      d1_s4_q    <= front_i.d1;
    end
    if (en_i[1]) begin
      off2_q    <= off2_d;
      sens2_q   <= sens2_d;
      off_s5_q  <= off_s4_q;
      sens_s5_q <= sens_s4_q;
      d1_s5_q   <= d1_s4_q;
    end
    if (en_i[2]) begin
      c_q <= c_d;
    end
  end

  assign corr_o = c_q;

endmodule

### sv/ptc_scale.sv
// stages 7 to 11: pressure product in two halves, truncating divides, output register
module ptc_scale (
  input  logic                            clk_i,
  input  logic [4:0]                      en_i,
  input  ptc_pkg::corr_t                  corr_i,
  output logic signed [ptc_pkg::OutW-1:0] pressure_out_o
);

  logic [43:0]                       lo_d, lo_q;
  logic signed [43:0]                hi_d, hi_q;
  logic signed [63:0]                prod_d, prod_q, prod_b;
  logic signed [42:0]                quo_d, quo_q;
  logic signed [43:0]                x_d, x_q, x_b;
  logic signed [ptc_pkg::CorrW-1:0]  off_s7_q, off_s8_q, off_s9_q;
  logic signed [ptc_pkg::OutW-1:0]   p_d, p_q;

  // stage 7: SENS * D1 split into low and high partial products
  assign lo_d = {24'b0, corr_i.sensc[19:0]} * {20'b0, corr_i.d1};
  assign hi_d = $signed(corr_i.sensc[ptc_pkg::CorrW-1:20]) * $signed({1'b0, corr_i.d1});

  // stage 8: recombine the halves
  assign prod_d = $signed({hi_q, 20'b0}) + $signed({20'b0, lo_q});

  // stage 9: divide by 2^21 toward zero
  assign prod_b = prod_q + $signed({43'b0, {ptc_pkg::SensDivShift{prod_q[63]}}});
  assign quo_d  = prod_b[63:ptc_pkg::SensDivShift];

  // stage 10: subtract the corrected offset
  assign x_d = $signed({quo_q[42], quo_q})
             - $signed({{4{off_s9_q[ptc_pkg::CorrW-1]}}, off_s9_q});

  // stage 11: divide by 2^15 toward zero; the quotient stays within 29 bits,
  // so the 32-bit clamp never engages and a sign extension suffices
  assign x_b = x_q + $signed({29'b0, {ptc_pkg::PDivShift{x_q[43]}}});
  assign p_d = $signed({{3{x_b[43]}}, x_b[43:ptc_pkg::PDivShift]});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      off_s7_q <= corr_i.offc;
    end
    if (en_i[1]) begin
      prod_q   <= prod_d;
      off_s8_q <= off_s7_q;
    end
    if (en_i[2]) begin
      quo_q    <= quo_d;
      off_s9_q <= off_s8_q;
    end
    if (en_i[3]) begin
      x_q <= x_d;
    end
    if (en_i[4]) begin
      p_q <= p_d;
    end
  end

  assign pressure_out_o = p_q;

endmodule

### sv/ptc_checker.sv
// port-level checks of the compensation block and their bind
module ptc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [ptc_pkg::OutW-1:0] out_data_i
);

  logic [3:0] occ_q, occ_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // beats inside the block
  always_comb begin
    occ_d = occ_q;
    if (in_beat && !out_beat) begin
      occ_d = occ_q + 4'd1;
    end else if (!in_beat && out_beat) begin
      occ_d = occ_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // a stalled result stays offered with its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output beat dropped or changed while stalled");

  // a ready sink never backs up the pipeline
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is ready");

  // never more beats inside than stages
  a_occ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(ptc_pkg::NStages))
    else $error("more beats in flight than pipeline stages");

  // no result without an accepted input
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 4'd0)
    else $error("output beat without a pending input");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.pressure_out)
);

### verif/ptc_checker.sv
// checker: predicts compensated pressure from watched beats and compares results
module ptc_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ptc_in_if    in_mon,
  ptc_out_if   out_mon,
  ptc_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   in_beats_o,
  output int   out_beats_o,
  output int   warm_o,
  output int   cold_o,
  output int   vcold_o
);

  localparam int     RawW      = ptc_pkg::RawW;
  localparam int     CfgW      = ptc_pkg::CfgW;
  localparam int     OutW      = ptc_pkg::OutW;
  localparam longint PosLimit  = 64'sd2147483647;
  localparam longint NegLimit  = -64'sd2147483648;
  localparam int     ReportMax = 10;

  typedef enum logic [1:0] {
    BandWarm,
    BandCold,
    BandVeryCold
  } band_e;

  // one expected pressure with the conversion pair that caused it
  typedef struct packed {
    logic [RawW-1:0]        raw_p;
    logic [RawW-1:0]        raw_t;
    logic signed [OutW-1:0] pressure;
  } pressure_due_t;

  // shadow copy of the calibration words
  logic [CfgW-1:0] sens_base_q;
  logic [CfgW-1:0] offset_base_q;
  logic [CfgW-1:0] sens_tempco_q;
  logic [CfgW-1:0] offset_tempco_q;
  logic [CfgW-1:0] ref_temp_q;
  logic [CfgW-1:0] temp_slope_q;

  pressure_due_t pressure_due_q [$];

  // second-order compensation at 64 bits, saturated to the output width
  function automatic logic signed [OutW-1:0] compensated_pressure(
    input  logic [RawW-1:0] d1,
    input  logic [RawW-1:0] d2,
    output band_e           band
  );
    longint dt, temp, off, sens, dev, sq, cold_dev, off2, sens2, p;
    dt   = longint'(d2) - (longint'(ref_temp_q) <<< ptc_pkg::RefTempSh);
    temp = ptc_pkg::TempRef + ((dt * longint'(temp_slope_q)) >>> ptc_pkg::TempShift);
    off  = (longint'(offset_base_q) <<< ptc_pkg::OffBaseSh) +
           ((longint'(offset_tempco_q) * dt) >>> ptc_pkg::OffShift);
    sens = (longint'(sens_base_q) <<< ptc_pkg::SensBaseSh) +
           ((longint'(sens_tempco_q) * dt) >>> ptc_pkg::SensShift);
    dev  = temp - ptc_pkg::TempRef;
    sq   = dev * dev;
    if (temp < ptc_pkg::TempRef) begin
      off2  = 3 * sq / 2;
      sens2 = 5 * sq / 8;
      band  = BandCold;
      if (temp < -ptc_pkg::TempCold) begin
        cold_dev = temp + ptc_pkg::TempCold;
        off2     = off2 + 7 * (cold_dev * cold_dev);
        sens2    = sens2 + 4 * (cold_dev * cold_dev);
        band     = BandVeryCold;
      end
    end else begin
      off2  = sq / 16;
      sens2 = 0;
      band  = BandWarm;
    end
    off  = off - off2;
    sens = sens - sens2;
    // truncating divides toward zero
    p = ((sens * longint'(d1)) / (longint'(1) <<< ptc_pkg::SensDivShift) - off) /
        (longint'(1) <<< ptc_pkg::PDivShift);
    if (p > PosLimit) p = PosLimit;
    if (p < NegLimit) p = NegLimit;
    return p[OutW-1:0];
  endfunction

  // watch register writes, conversion beats and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    band_e         band;
    pressure_due_t due;
    if (!rst_ni) begin
      sens_base_q     <= '0;
      offset_base_q   <= '0;
      sens_tempco_q   <= '0;
      offset_tempco_q <= '0;
      ref_temp_q      <= '0;
      temp_slope_q    <= '0;
      pressure_due_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      in_beats_o   <= 0;
      out_beats_o  <= 0;
      warm_o       <= 0;
      cold_o       <= 0;
      vcold_o      <= 0;
    end else begin
      // register write beat, indexes beyond the last register are dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          ptc_pkg::RegSensBase:   sens_base_q     <= cfg_mon.data;
          ptc_pkg::RegOffBase:    offset_base_q   <= cfg_mon.data;
          ptc_pkg::RegSensTempco: sens_tempco_q   <= cfg_mon.data;
          ptc_pkg::RegOffTempco:  offset_tempco_q <= cfg_mon.data;
          ptc_pkg::RegRefTemp:    ref_temp_q      <= cfg_mon.data;
          ptc_pkg::RegTempSlope:  temp_slope_q    <= cfg_mon.data;
          default: ;
        endcase
      end
      // conversion beat: queue the expected pressure
      if (in_mon.valid && in_mon.ready) begin
        due.raw_p    = in_mon.raw_pressure;
        due.raw_t    = in_mon.raw_temperature;
        due.pressure = compensated_pressure(in_mon.raw_pressure,
                                            in_mon.raw_temperature, band);
        pressure_due_q.push_back(due);
        in_beats_o <= in_beats_o + 1;
        case (band)
          BandWarm: warm_o  <= warm_o + 1;
          BandCold: cold_o  <= cold_o + 1;
          default:  vcold_o <= vcold_o + 1;
        endcase
      end
      // result beat: compare with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        out_beats_o <= out_beats_o + 1;
        if (pressure_due_q.size() == 0) begin
          if (fail_count_o < ReportMax)
            $display("pressure beat %0d with nothing pending", out_mon.pressure_out);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = pressure_due_q.pop_front();
          if (out_mon.pressure_out !== due.pressure) begin
            if (fail_count_o < ReportMax)
              $display("pressure mismatch for p=%0d t=%0d: expected %0d, got %0d",
                       due.raw_p, due.raw_t, due.pressure, out_mon.pressure_out);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= pressure_due_q.size();
    end
  end

endmodule

### verif/pressure_temperature_compensation_test.sv
// testbench top: clock, reset, conversion and calibration stimulus, verdict
module pressure_temperature_compensation_test;

  localparam int              RawW       = ptc_pkg::RawW;
  localparam int              CfgW       = ptc_pkg::CfgW;
  localparam int              CfgIdxW    = ptc_pkg::CfgIdxW;
  localparam logic [RawW-1:0] RawMax     = '1;
  localparam int              IdlePct    = 28;
  localparam int              RandItems  = 305;
  localparam int              RandPhases = 6;

  logic clk_i;
  logic rst_ni;

  ptc_in_if  in_ch ();
  ptc_out_if out_ch ();
  ptc_cfg_if cfg_ch ();

  int fail_count, pending, in_beats, out_beats, warm_cnt, cold_cnt, vcold_cnt;
  int settings;

  // stretch controls, changed at the rising edge and read at the falling one
  logic steady;
  logic hold_out;

  logic [CfgW-1:0] cal [6];

  pressure_temperature_compensation i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  ptc_tb_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .in_beats_o   (in_beats),
    .out_beats_o  (out_beats),
    .warm_o       (warm_cnt),
    .cold_o       (cold_cnt),
    .vcold_o      (vcold_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #400000;
    $display("run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // no-idle stretch, then a long output hold while conversions keep coming
  initial begin
    steady   = 1'b0;
    hold_out = 1'b0;
    do @(posedge clk_i); while (in_beats < 600);
    steady = 1'b1;
    repeat (300) @(posedge clk_i);
    steady = 1'b0;
    do @(posedge clk_i); while (in_beats < 1200);
    hold_out = 1'b1;
    repeat (90) @(posedge clk_i);
    hold_out = 1'b0;
  end

  // result side ready with random stalls
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = steady || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  function automatic logic [CfgIdxW-1:0] reg_index(input int i);
    case (i)
      0:       return ptc_pkg::RegSensBase;
      1:       return ptc_pkg::RegOffBase;
      2:       return ptc_pkg::RegSensTempco;
      3:       return ptc_pkg::RegOffTempco;
      4:       return ptc_pkg::RegRefTemp;
      default: return ptc_pkg::RegTempSlope;
    endcase
  endfunction

  // raw temperature whose first-order temperature lands exactly on deg, unless c6 is zero or it is clamped
  function automatic logic [RawW-1:0] raw_temp_for(input longint deg,
                                                   input logic [CfgW-1:0] c5,
                                                   input logic [CfgW-1:0] c6);
    longint num, dt, d2;
    if (c6 == 0) return RawW'(longint'(c5) <<< ptc_pkg::RefTempSh);
    num = (deg - ptc_pkg::TempRef) <<< ptc_pkg::TempShift;
    dt  = num / longint'(c6);
    if (dt * longint'(c6) < num) dt = dt + 1;
    d2 = dt + (longint'(c5) <<< ptc_pkg::RefTempSh);
    if (d2 < 0) d2 = 0;
    if (d2 > longint'(RawMax)) d2 = longint'(RawMax);
    return d2[RawW-1:0];
  endfunction

  // half uniform, some around the reference point, some at the ends
  function automatic logic [RawW-1:0] pick_raw_temp(input logic [CfgW-1:0] c5);
    int unsigned mode;
    longint span, t;
    mode = $urandom_range(0, 9);
    if (mode < 5) return RawW'($urandom_range(0, RawMax));
    if (mode < 8) begin
      span = longint'(1) <<< $urandom_range(0, 20);
      t = (longint'(c5) <<< ptc_pkg::RefTempSh) + longint'($urandom_range(0, 2 * span))
        - span;
      if (t < 0) t = 0;
      if (t > longint'(RawMax)) t = longint'(RawMax);
      return t[RawW-1:0];
    end
    return $urandom_range(0, 1) ? RawMax : '0;
  endfunction

  function automatic logic [RawW-1:0] pick_raw_pressure();
    case ($urandom_range(0, 19))
      0, 1:    return RawMax;
      2:       return '0;
      3, 4, 5: return RawW'($urandom_range(0, 255));
      default: return RawW'($urandom_range(0, RawMax));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_cal_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CfgW'($urandom());
    endcase
  endfunction

  // offer one conversion pair, random gaps before it, held until the beat
  task automatic send_conversion(input logic [RawW-1:0] p, input logic [RawW-1:0] t);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid           = 1'b0;
      in_ch.raw_pressure    = RawW'($urandom());
      in_ch.raw_temperature = RawW'($urandom());
      @(negedge clk_i);
    end
    in_ch.valid           = 1'b1;
    in_ch.raw_pressure    = p;
    in_ch.raw_temperature = t;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  // drop the input and wait until every pressure has come back
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // write all six words, optionally with a write to an unused index before and after them
  task automatic load_calibration(input bit stray);
    if (stray)
      write_reg(CfgIdxW'($urandom_range(ptc_pkg::RegTempSlope + 1, (1 << CfgIdxW) - 1)),
                CfgW'($urandom()));
    for (int i = 0; i < 6; i++) begin
      write_reg(reg_index(i), cal[i]);
    end
    if (stray)
      write_reg(CfgIdxW'($urandom_range(ptc_pkg::RegTempSlope + 1, (1 << CfgIdxW) - 1)),
                CfgW'($urandom()));
    cfg_ch.valid = 1'b0;
    settings++;
  endtask

  // main stimulus and verdict
  initial begin
    longint band_deg [4];
    settings              = 0;
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.raw_pressure    = '0;
    in_ch.raw_temperature = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset calibration, all words zero
    send_conversion(RawMax, RawMax);
    send_conversion('0, '0);
    wait_drained();

    // typical calibration around the band edges
    cal[0] = 16'd40127; cal[1] = 16'd36924; cal[2] = 16'd23317;
    cal[3] = 16'd23282; cal[4] = 16'd33464; cal[5] = 16'd28312;
    load_calibration(1'b0);
    band_deg[0] = ptc_pkg::TempRef;
    band_deg[1] = ptc_pkg::TempRef - 1;
    band_deg[2] = -ptc_pkg::TempCold;
    band_deg[3] = -ptc_pkg::TempCold - 1;
    for (int i = 0; i < 4; i++) begin
      send_conversion(RawMax, raw_temp_for(band_deg[i], cal[4], cal[5]));
      send_conversion(RawW'($urandom_range(0, RawMax)),
                      raw_temp_for(band_deg[i], cal[4], cal[5]));
    end
    send_conversion('0, '0);
    send_conversion(RawMax, '0);
    send_conversion('0, RawMax);
    send_conversion(RawMax, RawMax);
    wait_drained();

    // every word at its maximum, deepest cold band
    for (int i = 0; i < 6; i++) cal[i] = '1;
    load_calibration(1'b0);
    send_conversion('0, '0);
    send_conversion(RawMax, '0);
    send_conversion(RawMax, RawMax);
    send_conversion('0, RawMax);
    send_conversion(RawMax, raw_temp_for(-ptc_pkg::TempCold - 1, cal[4], cal[5]));
    wait_drained();

    // writes to unused indexes must leave the words alone
    load_calibration(1'b1);
    send_conversion(RawMax, '0);
    send_conversion(RawW'($urandom_range(0, RawMax)), RawW'($urandom_range(0, RawMax)));
    wait_drained();

    // random phases: zero words, max words, then random words
    for (int ph = 0; ph < RandPhases; ph++) begin
      for (int i = 0; i < 6; i++) begin
        if (ph == 0) cal[i] = '0;
        else if (ph == 1) cal[i] = '1;
        else cal[i] = pick_cal_word();
      end
      load_calibration($urandom_range(0, 1));
      for (int n = 0; n < RandItems; n++) begin
        send_conversion(pick_raw_pressure(), pick_raw_temp(cal[4]));
      end
      wait_drained();
    end

    // let any stray beat show up
    repeat (2 * ptc_pkg::NStages) @(negedge clk_i);

    $display("checked %0d compensated pressures over %0d calibration settings",
             out_beats, settings);
    $display("temperature bands: %0d warm, %0d cold, %0d very cold",
             warm_cnt, cold_cnt, vcold_cnt);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ptc_pkg.sv
sv/ptc_if.sv
sv/ptc_pipe_ctrl.sv
sv/ptc_front.sv
sv/ptc_corr.sv
sv/ptc_scale.sv
sv/pressure_temperature_compensation.sv
sv/ptc_checker.sv
verif/ptc_checker.sv
verif/pressure_temperature_compensation_test.sv
